[src/bit_deposit_extract_unit_core_macros.svh]
`ifndef BIT_DEPOSIT_EXTRACT_UNIT_CORE_MACROS_SVH
`define BIT_DEPOSIT_EXTRACT_UNIT_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BDEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain property checked on every clock edge outside reset.
`define BDEU_ASSERT_ALW(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

[src/bdeu_pkg.sv]
package bdeu_pkg;

	localparam int unsigned DATA_W = 64;

	localparam logic CMD_DEPOSIT = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

endpackage

[src/bdeu_cell.sv]
module bdeu_cell #(
	parameter int unsigned W     = 64,
	parameter int unsigned CNT_W = $clog2(W + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_cmd,
	input  logic [W-1:0]     in_data,
	input  logic [W-1:0]     in_msk,
	input  logic [W-1:0]     in_acc,
	input  logic [CNT_W-1:0] in_cnt,
	output logic             out_valid,
	output logic             out_cmd,
	output logic [W-1:0]     out_data,
	output logic [W-1:0]     out_msk,
	output logic [W-1:0]     out_acc,
	output logic [CNT_W-1:0] out_cnt
);

	logic             valid_q;
	logic             cmd_q;
	logic [W-1:0]     data_q;
	logic [W-1:0]     msk_q;
	logic [W-1:0]     acc_q;
	logic [CNT_W-1:0] cnt_q;

	logic             sel;
	logic             bit_in;
	logic [W-1:0]     data_n;
	logic [W-1:0]     acc_n;
	logic [CNT_W-1:0] cnt_n;

	// Each cell looks at bit 0 of the mask; the mask moves down one place per cell.
	always_comb begin
		sel    = in_msk[0];
		bit_in = sel & in_data[0];
		cnt_n  = in_cnt + CNT_W'(sel);
		if (in_cmd == bdeu_pkg::CMD_EXTRACT) begin
			data_n = in_data >> 1;
			acc_n  = in_acc | ({{(W-1){1'b0}}, bit_in} << in_cnt);
		end else begin
			data_n = sel ? (in_data >> 1) : in_data;
			acc_n  = {bit_in, in_acc[W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= in_cmd;
		data_q <= data_n;
		msk_q  <= in_msk >> 1;
		acc_q  <= acc_n;
		cnt_q  <= cnt_n;
	end

	assign out_valid = valid_q;
	assign out_cmd   = cmd_q;
	assign out_data  = data_q;
	assign out_msk   = msk_q;
	assign out_acc   = acc_q;
	assign out_cnt   = cnt_q;

endmodule

[src/bit_deposit_extract_unit_core.sv]
// done rises when a beat taken on start leaves the register of the last of the WORD_BITS cells.
// Throughput: one beat per cycle; busy is never high, since each of the
// WORD_BITS cells in the chain handles one bit position of a new beat every cycle.
// The receiver cannot stall: every result is shown on done for one cycle.
// Reset clears the valid bit of every cell; data registers are not reset.
module bit_deposit_extract_unit_core #(
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic [bdeu_pkg::DATA_W-1:0] value,
	input  logic [bdeu_pkg::DATA_W-1:0] mask,
	output logic                        done,
	output logic [bdeu_pkg::DATA_W-1:0] result
);

	localparam int unsigned W     = WORD_BITS;
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic             valid_c [W+1];
	logic             cmd_c   [W+1];
	logic [W-1:0]     data_c  [W+1];
	logic [W-1:0]     msk_c   [W+1];
	logic [W-1:0]     acc_c   [W+1];
	logic [CNT_W-1:0] cnt_c   [W+1];

	assign busy = 1'b0;

	assign valid_c[0] = start & ~busy;
	assign cmd_c[0]   = command;
	assign data_c[0]  = value[W-1:0];
	assign msk_c[0]   = mask[W-1:0];
	assign acc_c[0]   = '0;
	assign cnt_c[0]   = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		bdeu_cell #(
			.W     (W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_cmd    (cmd_c[i]),
			.in_data   (data_c[i]),
			.in_msk    (msk_c[i]),
			.in_acc    (acc_c[i]),
			.in_cnt    (cnt_c[i]),
			.out_valid (valid_c[i+1]),
			.out_cmd   (cmd_c[i+1]),
			.out_data  (data_c[i+1]),
			.out_msk   (msk_c[i+1]),
			.out_acc   (acc_c[i+1]),
			.out_cnt   (cnt_c[i+1])
		);
	end

	assign done   = valid_c[W];
	assign result = bdeu_pkg::DATA_W'(acc_c[W]);

endmodule

[src/bdeu_chk.sv]
`include "bit_deposit_extract_unit_core_macros.svh"

module bdeu_chk #(
	parameter int unsigned WORD_BITS = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        command,
	input logic [bdeu_pkg::DATA_W-1:0] value,
	input logic [bdeu_pkg::DATA_W-1:0] mask,
	input logic                        done,
	input logic [bdeu_pkg::DATA_W-1:0] result
);

	logic [bdeu_pkg::DATA_W-1:0] narrow_mask;

	assign narrow_mask = mask << (bdeu_pkg::DATA_W - WORD_BITS);

	`BDEU_ASSERT_ALW(a_never_busy, clk, arst_n, !busy, "busy raised")
	`BDEU_ASSERT_IMP(a_beat_done, clk, arst_n, start && !busy, ##WORD_BITS done, "beat lost")
	`BDEU_ASSERT_IMP(a_done_beat, clk, arst_n, done, $past(start && !busy, WORD_BITS), "extra result")
	`BDEU_ASSERT_IMP(a_empty_mask, clk, arst_n, done && ($past(narrow_mask, WORD_BITS) == '0), result == '0, "empty mask result not zero")

endmodule

bind bit_deposit_extract_unit_core bdeu_chk #(.WORD_BITS(WORD_BITS)) u_bdeu_chk (.*);

[verif/testbench.sv]
module testbench;

	localparam int unsigned DATA_W = bdeu_pkg::DATA_W;
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned RANDOM_BEATS = 1630;
	localparam int unsigned QUIET_TAIL = 200;

	class deposit_extract_ledger;
		logic [DATA_W-1:0] expected_words[$];
		int unsigned lanes;
		int errors;

		function new(int unsigned word_bits);
			lanes = (word_bits > DATA_W) ? DATA_W : word_bits;
			errors = 0;
		endfunction

		function logic [DATA_W-1:0] scatter(logic [DATA_W-1:0] packed_bits,
				logic [DATA_W-1:0] sel);
			logic [DATA_W-1:0] word;
			int unsigned src;
			word = '0;
			src = 0;
			for (int unsigned i = 0; i < lanes; i++) begin
				if (sel[i]) begin
					word[i] = packed_bits[src];
					src++;
				end
			end
			return word;
		endfunction

		function logic [DATA_W-1:0] gather(logic [DATA_W-1:0] word,
				logic [DATA_W-1:0] sel);
			logic [DATA_W-1:0] packed_bits;
			int unsigned dst;
			packed_bits = '0;
			dst = 0;
			for (int unsigned i = 0; i < lanes; i++) begin
				if (sel[i]) begin
					packed_bits[dst] = word[i];
					dst++;
				end
			end
			return packed_bits;
		endfunction

		function void note_operands(logic cmd, logic [DATA_W-1:0] val,
				logic [DATA_W-1:0] msk);
			if (cmd == bdeu_pkg::CMD_EXTRACT) begin
				expected_words.push_back(gather(val, msk));
			end else begin
				expected_words.push_back(scatter(val, msk));
			end
		endfunction

		function void check_result(logic [DATA_W-1:0] res);
			logic [DATA_W-1:0] want;
			if (expected_words.size() == 0) begin
				$error("result: expected none, actual %h", res);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (res !== want) begin
				$error("result: expected %h, actual %h", want, res);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_words.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic command;
	logic [DATA_W-1:0] value;
	logic [DATA_W-1:0] mask;
	logic done;
	logic [DATA_W-1:0] result;

	deposit_extract_ledger ledger = new(WORD_BITS);

	bit_deposit_extract_unit_core #(
		.WORD_BITS(WORD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.mask(mask),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				ledger.check_result(result);
			end else if (done !== 1'b0) begin
				$error("done: expected 0 or 1, actual %b", done);
				ledger.errors++;
			end
			if (start && busy === 1'b0) begin
				ledger.note_operands(command, value, mask);
			end
		end
	end

	task automatic send_beat(logic cmd, logic [DATA_W-1:0] val, logic [DATA_W-1:0] msk);
		start <= 1'b1;
		command <= cmd;
		value <= val;
		mask <= msk;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic pause_sender(int unsigned cycles);
		start <= 1'b0;
		command <= 1'($urandom_range(0, 1));
		value <= {$urandom, $urandom};
		mask <= {$urandom, $urandom};
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DATA_W-1:0] random_mask();
		logic [DATA_W-1:0] m;
		int unsigned lo;
		int unsigned len;
		case ($urandom_range(0, 6))
			0: begin
				m = random_word() & random_word() & random_word();
			end
			1: begin
				m = random_word() | random_word();
			end
			2: begin
				lo = $urandom_range(0, DATA_W - 1);
				len = $urandom_range(1, DATA_W - lo);
				m = (len == DATA_W) ? '1 : (((64'd1 << len) - 64'd1) << lo);
			end
			3: begin
				m = $urandom_range(0, 1) ? '1 : '0;
			end
			4: begin
				m = 64'd1 << $urandom_range(0, DATA_W - 1);
			end
			default: begin
				m = random_word();
			end
		endcase
		return m;
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '1;
			1: v = '0;
			default: v = random_word();
		endcase
		return v;
	endfunction

	task automatic run_directed();
		logic cmd;
		for (int k = 0; k < 2; k++) begin
			cmd = (k == 0) ? bdeu_pkg::CMD_DEPOSIT : bdeu_pkg::CMD_EXTRACT;
			send_beat(cmd, '1, '0);
			send_beat(cmd, '1, '1);
			send_beat(cmd, '0, '1);
			send_beat(cmd, 64'h5555_5555_5555_5555, '1);
			send_beat(cmd, '1, 64'hAAAA_AAAA_AAAA_AAAA);
			send_beat(cmd, 64'h0123_4567_89AB_CDEF, 64'hF0F0_0FF0_FF00_000F);
			send_beat(cmd, '1, 64'h8000_0000_0000_0000);
			send_beat(cmd, '1, 64'h0000_0000_0000_0001);
			send_beat(cmd, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_0000_0000);
			send_beat(cmd, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = bdeu_pkg::CMD_DEPOSIT;
		value = '0;
		mask = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
			if (n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
				pause_sender($urandom_range(1, 10));
			end
			send_beat($urandom_range(0, 1) ? bdeu_pkg::CMD_EXTRACT : bdeu_pkg::CMD_DEPOSIT,
				random_value(), random_mask());
		end
		start <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
		repeat (WORD_BITS + 16) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("bit_deposit_extract_unit_core: match");
		end else begin
			$display("bit_deposit_extract_unit_core: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("bit_deposit_extract_unit_core: mismatch");
		$finish;
	end

endmodule
